### rtl/sst_pkg.sv
// Shared types and constants of the stream statistics table.
package sst_pkg;

  // Operation codes carried by an input beat.
  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_DUMP   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  // Kinds of result beat.
  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ENTRY  = 2'd2
  } kind_t;

  // Outcome of a record operation.
  typedef enum logic [1:0] {
    STAT_NEW      = 2'd0,
    STAT_KNOWN    = 2'd1,
    STAT_MISMATCH = 2'd2,
    STAT_DROPPED  = 2'd3
  } status_t;

  // Depth of the command queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // Largest value of the saturating frame count.
  localparam logic [31:0] TALLY_MAX = 32'hFFFF_FFFF;

  // A classified command as it travels through the queue.
  typedef struct packed {
    op_t                op;
    logic signed [31:0] stream_id;
    logic [31:0]        frame_type;
    logic [63:0]        frame_time;
  } cmd_t;

  // Write side of the queue.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_push_t;

  // Read side of the queue.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  // One result beat as held in the output register.
  typedef struct packed {
    kind_t              result_kind;
    status_t            status;
    logic [5:0]         stream_count;
    logic signed [31:0] entry_stream_id;
    logic [31:0]        entry_frame_type;
    logic [63:0]        entry_start_time;
    logic [63:0]        entry_end_time;
    logic [31:0]        entry_frame_count;
    logic               last;
  } result_t;

endpackage

### rtl/sst_if.sv
// Channel interfaces of the stream statistics table.
interface sst_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [31:0] stream_id;
  logic [31:0]        frame_type;
  logic [63:0]        frame_time;

  modport source (output valid, output operation, output stream_id, output frame_type,
                  output frame_time, input ready);
  modport sink (input valid, input operation, input stream_id, input frame_type,
                input frame_time, output ready);
endinterface

interface sst_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic [1:0]         status;
  logic [5:0]         stream_count;
  logic signed [31:0] entry_stream_id;
  logic [31:0]        entry_frame_type;
  logic [63:0]        entry_start_time;
  logic [63:0]        entry_end_time;
  logic [31:0]        entry_frame_count;
  logic               last;

  modport source (output valid, output result_kind, output status, output stream_count,
                  output entry_stream_id, output entry_frame_type, output entry_start_time,
                  output entry_end_time, output entry_frame_count, output last,
                  input ready);
  modport sink (input valid, input result_kind, input status, input stream_count,
                input entry_stream_id, input entry_frame_type, input entry_start_time,
                input entry_end_time, input entry_frame_count, input last,
                output ready);
endinterface

### rtl/sst_front.sv
// Front part: accepts input beats, decodes the operation and queues valid commands.
module sst_front (
  sst_in_if.sink           in_chan,
  input  logic             q_full,
  output sst_pkg::q_push_t q_push
);

  // A beat is taken whenever the queue has room; unused codes are dropped here.
  assign in_chan.ready = !q_full;

  // Decode the operation and build the queued command.
  always_comb begin
    q_push.cmd.op         = sst_pkg::op_t'(in_chan.operation);
    q_push.cmd.stream_id  = in_chan.stream_id;
    q_push.cmd.frame_type = in_chan.frame_type;
    q_push.cmd.frame_time = in_chan.frame_time;
    unique case (in_chan.operation) inside
      sst_pkg::OP_RECORD, sst_pkg::OP_DUMP, sst_pkg::OP_CLEAR: begin
        q_push.valid = in_chan.valid && !q_full;
      end
      default: begin
        q_push.valid = 1'b0;
      end
    endcase
  end

endmodule

### rtl/sst_queue.sv
// Short command queue that decouples the front part from the table engine.
module sst_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  sst_pkg::q_push_t q_push,
  output logic             q_full,
  output sst_pkg::q_head_t q_head,
  input  logic             q_pop
);

  localparam int QPW = (sst_pkg::QUEUE_DEPTH > 1) ? $clog2(sst_pkg::QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(sst_pkg::QUEUE_DEPTH + 1);
  localparam logic [QPW-1:0] LAST_SLOT = QPW'(sst_pkg::QUEUE_DEPTH - 1);
  localparam logic [QCW-1:0] FULL_FILL = QCW'(sst_pkg::QUEUE_DEPTH);

  sst_pkg::cmd_t    slots_r [sst_pkg::QUEUE_DEPTH];
  logic [QPW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   fill_r, fill_nxt;
  logic             do_push, do_pop;

  assign q_full      = (fill_r == FULL_FILL);
  assign q_head.valid = (fill_r != '0);
  assign q_head.cmd   = slots_r[rd_ptr_r];

  assign do_push = q_push.valid && !q_full;
  assign do_pop  = q_pop && q_head.valid;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + QPW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + QPW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   fill_nxt = fill_r + QCW'(1);
      2'b01:   fill_nxt = fill_r - QCW'(1);
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Command storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= q_push.cmd;
    end
  end

endmodule

### rtl/sst_back.sv
// Table engine: key lookup, entry update, dump sequencing and the output register.
module sst_back #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  sst_pkg::q_head_t q_head,
  output logic             q_pop,
  sst_out_if.source        out_chan
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_HEADER,
    S_DUMP_READ,
    S_DUMP_OUT
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              aborted_r, aborted_nxt;
  sst_pkg::cmd_t     cmd_r, cmd_nxt;
  logic              hit_r, hit_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [IW-1:0]     dump_idx_r, dump_idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  sst_pkg::result_t  res_r, res_nxt;

  // Table storage: keys in flip-flops for the parallel compare, the rest in memories.
  logic [31:0]       key_r        [TABLE_DEPTH];
  logic [31:0]       type_mem     [TABLE_DEPTH];
  logic [63:0]       first_mem    [TABLE_DEPTH];
  logic [63:0]       latest_mem   [TABLE_DEPTH];
  logic [31:0]       tally_mem    [TABLE_DEPTH];
  logic [31:0]       rd_key_r, rd_type_r, rd_tally_r;
  logic [63:0]       rd_first_r, rd_latest_r;

  logic [IW-1:0]     rd_addr;
  logic [IW-1:0]     wr_addr;
  logic              wr_new, wr_hit;
  logic [31:0]       tally_wr;
  logic              load_ok;
  logic              match_any;
  logic [IW-1:0]     match_idx;
  logic              dump_last;

  assign load_ok = !out_valid_r || out_chan.ready;

  // Compare the queue head's identifier against every occupied entry at once.
  // Keys in the table are unique, so OR-ing the indices of the hits gives the hit.
  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if ((CW'(i) < count_r) && (key_r[i] == q_head.cmd.stream_id)) begin
        match_any = 1'b1;
        match_idx = match_idx | IW'(i);
      end
    end
  end

  assign dump_last = ((CW'(dump_idx_r) + CW'(1)) == count_r);

  // Sequencer: next state, table bookkeeping and the next output beat.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    aborted_nxt   = aborted_r;
    cmd_nxt       = cmd_r;
    hit_nxt       = hit_r;
    idx_nxt       = idx_r;
    dump_idx_nxt  = dump_idx_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    res_nxt       = res_r;
    q_pop         = 1'b0;
    wr_new        = 1'b0;
    wr_hit        = 1'b0;
    rd_addr       = dump_idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_head.valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_head.cmd;
          unique case (q_head.cmd.op)
            sst_pkg::OP_RECORD: begin
              hit_nxt   = match_any;
              idx_nxt   = match_idx;
              rd_addr   = match_idx;
              state_nxt = S_UPDATE;
            end
            sst_pkg::OP_DUMP: begin
              state_nxt = S_HEADER;
            end
            sst_pkg::OP_CLEAR: begin
              count_nxt   = '0;
              aborted_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      S_UPDATE: begin
        // Keep reading the looked-up slot so that its data survives an output stall.
        rd_addr = idx_r;
        if (load_ok) begin
          res_nxt             = '0;
          res_nxt.result_kind = sst_pkg::KIND_STATUS;
          res_nxt.last        = 1'b1;
          if (aborted_r) begin
            res_nxt.status = sst_pkg::STAT_DROPPED;
          end else if (hit_r) begin
            wr_hit         = 1'b1;
            res_nxt.status = (rd_type_r == cmd_r.frame_type) ? sst_pkg::STAT_KNOWN
                                                             : sst_pkg::STAT_MISMATCH;
          end else if (count_r == FULL_COUNT) begin
            aborted_nxt    = 1'b1;
            res_nxt.status = sst_pkg::STAT_DROPPED;
          end else begin
            wr_new         = 1'b1;
            count_nxt      = count_r + CW'(1);
            res_nxt.status = sst_pkg::STAT_NEW;
          end
          res_nxt.stream_count = 6'(count_nxt);
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end
      end

      S_HEADER: begin
        if (load_ok) begin
          res_nxt              = '0;
          res_nxt.result_kind  = sst_pkg::KIND_HEADER;
          res_nxt.stream_count = 6'(count_r);
          res_nxt.last         = (count_r == '0);
          out_valid_nxt        = 1'b1;
          dump_idx_nxt         = '0;
          state_nxt            = (count_r == '0) ? S_IDLE : S_DUMP_READ;
        end
      end

      S_DUMP_READ: begin
        // The read address is the dump index; the data is ready next cycle.
        state_nxt = S_DUMP_OUT;
      end

      S_DUMP_OUT: begin
        if (load_ok) begin
          res_nxt.result_kind       = sst_pkg::KIND_ENTRY;
          res_nxt.status            = sst_pkg::STAT_NEW;
          res_nxt.stream_count      = 6'(count_r);
          res_nxt.entry_stream_id   = rd_key_r;
          res_nxt.entry_frame_type  = rd_type_r;
          res_nxt.entry_start_time  = rd_first_r;
          res_nxt.entry_end_time    = rd_latest_r;
          res_nxt.entry_frame_count = rd_tally_r;
          res_nxt.last              = dump_last;
          out_valid_nxt             = 1'b1;
          if (dump_last) begin
            state_nxt = S_IDLE;
          end else begin
            dump_idx_nxt = dump_idx_r + IW'(1);
            state_nxt    = S_DUMP_READ;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      aborted_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      aborted_r   <= aborted_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    hit_r      <= hit_nxt;
    idx_r      <= idx_nxt;
    dump_idx_r <= dump_idx_nxt;
    res_r      <= res_nxt;
  end

  // Write port: a new stream fills the next free slot, a known one updates its slot.
  assign wr_addr  = wr_new ? count_r[IW-1:0] : idx_r;
  assign tally_wr = wr_new ? 32'd1 :
                    (rd_tally_r == sst_pkg::TALLY_MAX) ? rd_tally_r : rd_tally_r + 32'd1;

  always_ff @(posedge clk) begin
    if (wr_new) begin
      key_r[wr_addr]    <= cmd_r.stream_id;
      type_mem[wr_addr] <= cmd_r.frame_type;
      first_mem[wr_addr] <= cmd_r.frame_time;
    end
    if (wr_new || wr_hit) begin
      latest_mem[wr_addr] <= cmd_r.frame_time;
      tally_mem[wr_addr]  <= tally_wr;
    end
  end

  // Registered read port shared by lookup and dump.
  always_ff @(posedge clk) begin
    rd_key_r    <= key_r[rd_addr];
    rd_type_r   <= type_mem[rd_addr];
    rd_first_r  <= first_mem[rd_addr];
    rd_latest_r <= latest_mem[rd_addr];
    rd_tally_r  <= tally_mem[rd_addr];
  end

  // Drive the result channel from the output register.
  assign out_chan.valid             = out_valid_r;
  assign out_chan.result_kind       = res_r.result_kind;
  assign out_chan.status            = res_r.status;
  assign out_chan.stream_count      = res_r.stream_count;
  assign out_chan.entry_stream_id   = res_r.entry_stream_id;
  assign out_chan.entry_frame_type  = res_r.entry_frame_type;
  assign out_chan.entry_start_time  = res_r.entry_start_time;
  assign out_chan.entry_end_time    = res_r.entry_end_time;
  assign out_chan.entry_frame_count = res_r.entry_frame_count;
  assign out_chan.last              = res_r.last;

`ifndef SYNTHESIS
  // The table never holds more streams than it has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("stream count exceeds table depth");

  // The sticky abort can only be set once the table is full.
  a_abort_full: assert property (@(posedge clk) disable iff (!rst_n)
    aborted_r |-> (count_r == FULL_COUNT))
    else $error("abort set while table not full");

  // A record status is always the only, hence last, beat of its item.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.result_kind == sst_pkg::KIND_STATUS)) |-> res_r.last)
    else $error("record status without last");

  // Appending a stream grows the table by exactly one.
  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    wr_new |=> (count_r == $past(count_r) + CW'(1)))
    else $error("append did not grow the table by one");
`endif

endmodule

### rtl/stream_statistics_table_unit.sv
// Top level of the stream statistics table.
// Keeps up to TABLE_DEPTH streams keyed by stream ID and answers record, dump and clear
// beats on a valid/ready channel. A front part decodes each input beat (unused operation
// codes are swallowed) and places it in a two-entry command queue; the table engine behind
// it takes one command at a time. In the engine a record passes a parallel compare of the
// identifier against every held key with a registered read of that slot, then, once the
// output register can take a beat, the update of the slot and the load of its status beat.
// A dump loads its header beat and then takes a read state and an output state for each
// entry in turn, set by the single registered read port of the table memories. A clear
// gives no beat. Results wait in a single output register, so a stalled output holds the
// engine while the front keeps filling the queue.
module stream_statistics_table_unit #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  sst_in_if.sink     in_chan,
  sst_out_if.source  out_chan
);

  sst_pkg::q_push_t q_push;
  sst_pkg::q_head_t q_head;
  logic             q_full;
  logic             q_pop;

  sst_front u_front (
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push)
  );

  sst_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_full (q_full),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  sst_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

### test/tb_stream_statistics_table_unit.sv
// Self-checking testbench of the stream statistics table top level.
module tb_stream_statistics_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SLOTS = 32;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 360;
  localparam int MAX_SHOWN = 10;

  // Keeps its own copy of the stream table and the beats it must produce.
  class stream_table_scoreboard;
    sst_pkg::result_t pending_beats[$];
    int          used;
    bit          aborted;
    logic [31:0] key_tab[TABLE_SLOTS];
    logic [31:0] type_tab[TABLE_SLOTS];
    logic [63:0] first_tab[TABLE_SLOTS];
    logic [63:0] latest_tab[TABLE_SLOTS];
    logic [31:0] tally_tab[TABLE_SLOTS];
    int          errors;
    int          outcome_cnt[4];
    int          dumps;
    int          entry_beats;
    int          clears;
    int          beats_checked;

    function new();
      used = 0;
      aborted = 1'b0;
      errors = 0;
      dumps = 0;
      entry_beats = 0;
      clears = 0;
      beats_checked = 0;
      foreach (outcome_cnt[i]) outcome_cnt[i] = 0;
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= MAX_SHOWN) $display("ERROR: %s", msg);
    endfunction

    // Looks the identifier up, appends or updates its entry, and gives the outcome.
    function sst_pkg::status_t apply_record(logic [31:0] id, logic [31:0] ftype,
                                            logic [63:0] ftime);
      int slot;
      sst_pkg::status_t outcome;
      if (aborted) return sst_pkg::STAT_DROPPED;
      slot = -1;
      for (int i = 0; i < used; i++) begin
        if (slot < 0 && key_tab[i] == id) slot = i;
      end
      if (slot >= 0) begin
        outcome = (type_tab[slot] == ftype) ? sst_pkg::STAT_KNOWN : sst_pkg::STAT_MISMATCH;
      end else if (used == TABLE_SLOTS) begin
        aborted = 1'b1;
        return sst_pkg::STAT_DROPPED;
      end else begin
        slot = used;
        key_tab[slot] = id;
        type_tab[slot] = ftype;
        first_tab[slot] = ftime;
        tally_tab[slot] = '0;
        used++;
        outcome = sst_pkg::STAT_NEW;
      end
      latest_tab[slot] = ftime;
      if (tally_tab[slot] != sst_pkg::TALLY_MAX) tally_tab[slot]++;
      return outcome;
    endfunction

    // Builds one beat; a negative slot leaves every entry field at zero.
    function sst_pkg::result_t make_beat(sst_pkg::kind_t kind, sst_pkg::status_t st,
                                         int slot, bit last);
      sst_pkg::result_t beat;
      beat = '0;
      beat.result_kind = kind;
      beat.status = st;
      beat.stream_count = 6'(used);
      beat.last = last;
      if (slot >= 0) begin
        beat.entry_stream_id = key_tab[slot];
        beat.entry_frame_type = type_tab[slot];
        beat.entry_start_time = first_tab[slot];
        beat.entry_end_time = latest_tab[slot];
        beat.entry_frame_count = tally_tab[slot];
      end
      return beat;
    endfunction

    // Called for every accepted input beat.
    function void note_input(logic [1:0] op, logic [31:0] id, logic [31:0] ftype,
                             logic [63:0] ftime);
      sst_pkg::status_t outcome;
      case (op)
        sst_pkg::OP_RECORD: begin
          outcome = apply_record(id, ftype, ftime);
          outcome_cnt[outcome]++;
          pending_beats.push_back(make_beat(sst_pkg::KIND_STATUS, outcome, -1, 1'b1));
        end
        sst_pkg::OP_DUMP: begin
          dumps++;
          pending_beats.push_back(make_beat(sst_pkg::KIND_HEADER, sst_pkg::STAT_NEW, -1,
                                            used == 0));
          for (int i = 0; i < used; i++) begin
            pending_beats.push_back(make_beat(sst_pkg::KIND_ENTRY, sst_pkg::STAT_NEW, i,
                                              i == used - 1));
            entry_beats++;
          end
        end
        sst_pkg::OP_CLEAR: begin
          used = 0;
          aborted = 1'b0;
          clears++;
        end
        default: ;
      endcase
    endfunction

    function string field_diff(string name, logic [63:0] want, logic [63:0] got);
      if (want === got) return "";
      return $sformatf(" %s exp=%h got=%h", name, want, got);
    endfunction

    // Called for every accepted result beat.
    function void check_result(sst_pkg::result_t got);
      sst_pkg::result_t want;
      string diff;
      if (pending_beats.size() == 0) begin
        note_error($sformatf("result beat of kind %0d with none expected", got.result_kind));
        return;
      end
      want = pending_beats.pop_front();
      diff = {field_diff("result_kind", 64'(want.result_kind), 64'(got.result_kind)),
              field_diff("status", 64'(want.status), 64'(got.status)),
              field_diff("stream_count", 64'(want.stream_count), 64'(got.stream_count)),
              field_diff("entry_stream_id", 64'(want.entry_stream_id),
                         64'(got.entry_stream_id)),
              field_diff("entry_frame_type", 64'(want.entry_frame_type),
                         64'(got.entry_frame_type)),
              field_diff("entry_start_time", want.entry_start_time, got.entry_start_time),
              field_diff("entry_end_time", want.entry_end_time, got.entry_end_time),
              field_diff("entry_frame_count", 64'(want.entry_frame_count),
                         64'(got.entry_frame_count)),
              field_diff("last", 64'(want.last), 64'(got.last))};
      if (diff != "") note_error($sformatf("result beat %0d:%s", beats_checked, diff));
      beats_checked++;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   items_sent;
  stream_table_scoreboard sb;

  sst_in_if  in_if ();
  sst_out_if out_if ();

  stream_statistics_table_unit #(
    .TABLE_DEPTH(TABLE_SLOTS)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: ready is redrawn every cycle from the current stall rate.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Input monitor: every accepted beat updates the prediction.
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      sb.note_input(in_if.operation, in_if.stream_id, in_if.frame_type, in_if.frame_time);
    end
  end

  // Output monitor: every accepted beat is checked against the oldest expectation.
  always @(posedge clk) begin
    sst_pkg::result_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.result_kind = sst_pkg::kind_t'(out_if.result_kind);
      got.status = sst_pkg::status_t'(out_if.status);
      got.stream_count = out_if.stream_count;
      got.entry_stream_id = out_if.entry_stream_id;
      got.entry_frame_type = out_if.entry_frame_type;
      got.entry_start_time = out_if.entry_start_time;
      got.entry_end_time = out_if.entry_end_time;
      got.entry_frame_count = out_if.entry_frame_count;
      got.last = out_if.last;
      sb.check_result(got);
    end
  end

  // Drives one input beat, with random idle cycles ahead of it, and waits for acceptance.
  task automatic send_beat(logic [1:0] op, logic [31:0] id, logic [31:0] ftype,
                           logic [63:0] ftime);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.operation <= op;
    in_if.stream_id <= id;
    in_if.frame_type <= ftype;
    in_if.frame_time <= ftime;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // Holds the sender back until every expected result beat has come.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_beats.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_time();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] extreme_id();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // One episode: a clear, an optional fill past the table depth, then mixed traffic
  // on a small pool of streams with occasional type changes, dumps, clears and noise.
  task automatic run_episode();
    int          pool_n;
    int          len;
    int          k;
    int          pick;
    bit          fill;
    logic [31:0] ids[40];
    logic [31:0] types[40];
    fill = ($urandom_range(0, 99) < 30);
    pool_n = fill ? $urandom_range(TABLE_SLOTS + 1, TABLE_SLOTS + 4) : $urandom_range(1, 12);
    for (int i = 0; i < pool_n; i++) begin
      ids[i] = $urandom;
      types[i] = $urandom;
    end
    send_beat(sst_pkg::OP_CLEAR, $urandom, $urandom, rand_time());
    if (fill) begin
      for (int i = 0; i < pool_n; i++) begin
        send_beat(sst_pkg::OP_RECORD, ids[i], types[i], rand_time());
      end
      send_beat(sst_pkg::OP_DUMP, $urandom, $urandom, rand_time());
    end
    len = $urandom_range(10, 40);
    repeat (len) begin
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, pool_n - 1);
      if (pick < 70) begin
        send_beat(sst_pkg::OP_RECORD, ids[k],
                  ($urandom_range(0, 99) < 15) ? $urandom : types[k], rand_time());
      end else if (pick < 78) begin
        send_beat(sst_pkg::OP_RECORD, $urandom, $urandom, rand_time());
      end else if (pick < 88) begin
        send_beat(sst_pkg::OP_DUMP, $urandom, $urandom, rand_time());
      end else if (pick < 92) begin
        send_beat(sst_pkg::OP_CLEAR, $urandom, $urandom, rand_time());
      end else if (pick < 96) begin
        send_beat(OP_UNUSED, $urandom, $urandom, rand_time());
      end else begin
        send_beat(sst_pkg::OP_RECORD, extreme_id(), types[k], rand_time());
      end
    end
  endtask

  // Main sequence.
  initial begin
    int episode;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.operation = sst_pkg::OP_RECORD;
    in_if.stream_id = '0;
    in_if.frame_type = '0;
    in_if.frame_time = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    items_sent = 0;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty dump, extremes of every field, mismatch, unused code, clear.
    send_beat(sst_pkg::OP_DUMP, 32'h0, 32'h0, 64'h0);
    send_beat(sst_pkg::OP_RECORD, 32'h8000_0000, 32'h0, 64'h0);
    send_beat(sst_pkg::OP_RECORD, 32'h8000_0000, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_beat(sst_pkg::OP_RECORD, 32'h8000_0000, 32'h0, 64'h5);
    send_beat(sst_pkg::OP_RECORD, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_beat(sst_pkg::OP_RECORD, 32'h0, 32'h6D6F_6F76, 64'h8000_0000_0000_0000);
    send_beat(sst_pkg::OP_RECORD, 32'hFFFF_FFFF, 32'h0, 64'h1);
    send_beat(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_beat(sst_pkg::OP_DUMP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_beat(sst_pkg::OP_CLEAR, 32'h0, 32'h0, 64'h0);
    send_beat(sst_pkg::OP_DUMP, 32'h0, 32'h0, 64'h0);
    send_beat(sst_pkg::OP_RECORD, 32'h0, 32'h7472_616B, 64'h0000_0001_0000_0000);
    send_beat(sst_pkg::OP_RECORD, 32'h0, 32'h7472_616B, 64'h0000_0001_0000_0002);
    send_beat(OP_UNUSED, 32'h0, 32'h0, 64'h0);
    send_beat(sst_pkg::OP_DUMP, 32'h0, 32'h0, 64'h0);

    // Random episodes, cycling through the idling phases; each starts drained.
    items_sent = 0;
    episode = 0;
    while (items_sent < RANDOM_ITEMS) begin
      wait_drained();
      case (episode % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      run_episode();
      episode++;
    end

    // Let the last results come and give the block time to show any stray beat.
    wait_drained();
    repeat (40) @(posedge clk);

    $display("Run covered %0d checked result beats over %0d random items in %0d episodes.",
             sb.beats_checked, items_sent, episode);
    $display("Records: %0d new, %0d known, %0d type mismatch, %0d dropped; %0d dumps, %0d %s",
             sb.outcome_cnt[sst_pkg::STAT_NEW], sb.outcome_cnt[sst_pkg::STAT_KNOWN],
             sb.outcome_cnt[sst_pkg::STAT_MISMATCH], sb.outcome_cnt[sst_pkg::STAT_DROPPED],
             sb.dumps, sb.entry_beats, "entry beats; all mismatches counted below.");
    if (sb.errors == 0) begin
      $display("tb_stream_statistics_table_unit OK");
    end else begin
      $display("%0d mismatches found", sb.errors);
      $display("tb_stream_statistics_table_unit NOT OK");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("Timeout with %0d result beats still expected", sb.pending_beats.size());
    $display("tb_stream_statistics_table_unit NOT OK");
    $finish;
  end

endmodule
